// ===== src/qli_pkg.sv =====
// Package for the three-point quadratic interpolator.
// Holds the width constants, the status codes and the pipeline structs.
// Used by every module under src.
package qli_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS = 8;
  localparam int DW = COORD_WIDTH + 1;           // coordinate difference
  localparam int PW = COORD_WIDTH + DW;          // sample times difference
  localparam int SW = 2 * DW;                    // difference times difference
  localparam int TW = PW + SW;                   // one numerator term
  localparam int NW = TW + 2;                    // numerator
  localparam int LW = SW + 1;                    // linear numerator
  localparam int DENW = 3 * DW;                  // divisor
  localparam int QW = 32;                        // quotient and output value
  localparam int HW = NW - QW;                   // numerator above the quotient bits

  typedef enum logic [1:0] {
    ST_QUAD  = 2'd0,
    ST_LIN   = 2'd1,
    ST_UNDEF = 2'd2
  } status_t;

  typedef struct packed {
    logic    valid;
    status_t status;
    logic    neg;
    logic    ovf;
  } ctl_t;

  typedef struct packed {
    logic [DENW-1:0] rem;
    logic [QW-1:0]   lo;
    logic [DENW-1:0] md;
    logic [QW-1:0]   q;
    ctl_t            ctl;
  } div_t;

endpackage

// ===== src/qli_front.sv =====
// Front pipeline: differences, products and the Lagrange numerator and divisor.
// Five register stages. Depends on qli_pkg.
module qli_front import qli_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic signed [COORD_WIDTH-1:0] qx,
  input  logic signed [COORD_WIDTH-1:0] px0,
  input  logic signed [COORD_WIDTH-1:0] py0,
  input  logic signed [COORD_WIDTH-1:0] px1,
  input  logic signed [COORD_WIDTH-1:0] py1,
  input  logic signed [COORD_WIDTH-1:0] px2,
  input  logic signed [COORD_WIDTH-1:0] py2,
  output logic                   out_valid,
  output status_t                out_status,
  output logic signed [NW-1:0]   num,
  output logic signed [DENW-1:0] den
);

  // Stage 1: captured word.
  logic v1;
  logic signed [COORD_WIDTH-1:0] x_1, x0_1, y0_1, x1_1, y1_1, x2_1, y2_1;

  // Stage 2: differences.
  logic v2;
  logic signed [DW-1:0] a0_2, a1_2, a2_2, d01_2, d02_2, d12_2, dy_2;
  logic signed [COORD_WIDTH-1:0] y0_2, y1_2, y2_2;
  logic same_2;

  // Stage 3: first products.
  logic v3;
  logic signed [PW-1:0] py0_3, py1_3, py2_3;
  logic signed [SW-1:0] pa12_3, pa02_3, pa01_3, pdd_3, lin2_3;
  logic signed [PW-1:0] lin1_3;
  logic signed [DW-1:0] d12_3, d02_3;
  logic same_3;

  // Stage 4: terms and divisors.
  logic v4;
  logic signed [TW-1:0] t0_4, t1_4, t2_4;
  logic signed [DENW-1:0] det_4;
  logic signed [LW-1:0] lin_4;
  logic signed [DW-1:0] d02_4;
  logic same_4;

  logic signed [NW-1:0] sum_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    x_1  <= qx;
    x0_1 <= px0;
    y0_1 <= py0;
    x1_1 <= px1;
    y1_1 <= py1;
    x2_1 <= px2;
    y2_1 <= py2;

    a0_2  <= DW'(x_1) - DW'(x0_1);
    a1_2  <= DW'(x_1) - DW'(x1_1);
    a2_2  <= DW'(x_1) - DW'(x2_1);
    d01_2 <= DW'(x0_1) - DW'(x1_1);
    d02_2 <= DW'(x0_1) - DW'(x2_1);
    d12_2 <= DW'(x1_1) - DW'(x2_1);
    dy_2  <= DW'(y2_1) - DW'(y0_1);
    y0_2  <= y0_1;
    y1_2  <= y1_1;
    y2_2  <= y2_1;
    same_2 <= (x0_1 == x2_1);

    py0_3  <= PW'(y0_2) * PW'(d12_2);
    py1_3  <= PW'(y1_2) * PW'(d02_2);
    py2_3  <= PW'(y2_2) * PW'(d01_2);
    pa12_3 <= SW'(a1_2) * SW'(a2_2);
    pa02_3 <= SW'(a0_2) * SW'(a2_2);
    pa01_3 <= SW'(a0_2) * SW'(a1_2);
    pdd_3  <= SW'(d01_2) * SW'(d02_2);
    lin1_3 <= PW'(y0_2) * PW'(d02_2);
    lin2_3 <= SW'(a0_2) * SW'(dy_2);
    d12_3  <= d12_2;
    d02_3  <= d02_2;
    same_3 <= same_2;

    // The determinant is the product of the three abscissa differences.
    t0_4  <= TW'(py0_3) * TW'(pa12_3);
    t1_4  <= TW'(py1_3) * TW'(pa02_3);
    t2_4  <= TW'(py2_3) * TW'(pa01_3);
    det_4 <= DENW'(pdd_3) * DENW'(d12_3);
    // y0*(x2-x0) + (x-x0)*(y2-y0), with x2-x0 = -d02.
    lin_4 <= LW'(lin2_3) - LW'(lin1_3);
    d02_4 <= d02_3;
    same_4 <= same_3;
  end

  assign sum_4 = NW'(t0_4) - NW'(t1_4) + NW'(t2_4);

  always_ff @(posedge clk) begin
    if (det_4 != '0) begin
      out_status <= ST_QUAD;
      num <= sum_4;
      den <= det_4;
    end else if (same_4) begin
      out_status <= ST_UNDEF;
      num <= '0;
      den <= DENW'(1);
    end else begin
      out_status <= ST_LIN;
      num <= NW'(lin_4);
      den <= -DENW'(d02_4);
    end
  end

endmodule

// ===== src/qli_div_step.sv =====
// One restoring division step: one quotient bit per stage, registered.
// Depends on qli_pkg.
module qli_div_step import qli_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  div_t din,
  output div_t dout
);

  logic [DENW:0] sh;
  logic          ge;
  logic [DENW:0] diff;

  assign sh   = {din.rem, din.lo[QW-1]};
  assign ge   = sh >= {1'b0, din.md};
  assign diff = sh - {1'b0, din.md};

  // Only the valid bit is reset; the data fields follow it unconditionally.
  always_ff @(posedge clk) begin
    dout.rem        <= ge ? diff[DENW-1:0] : sh[DENW-1:0];
    dout.lo         <= {din.lo[QW-2:0], 1'b0};
    dout.md         <= din.md;
    dout.q          <= {din.q[QW-2:0], ge};
    dout.ctl.status <= din.ctl.status;
    dout.ctl.neg    <= din.ctl.neg;
    dout.ctl.ovf    <= din.ctl.ovf;
    if (rst) begin
      dout.ctl.valid <= 1'b0;
    end else begin
      dout.ctl.valid <= din.ctl.valid;
    end
  end

endmodule

// ===== src/qli_divider.sv =====
// Pipelined signed divider: magnitude and range check stage, then one stage per
// quotient bit. Depends on qli_pkg and qli_div_step.
module qli_divider import qli_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  status_t                in_status,
  input  logic signed [NW-1:0]   num,
  input  logic signed [DENW-1:0] den,
  output div_t                   dout
);

  logic [NW-1:0]   mn;
  logic [DENW-1:0] mdv;
  logic [HW-1:0]   hi;
  logic            ovf;
  div_t            stage [0:QW];

  assign mn  = num[NW-1] ? -num : num;
  assign mdv = den[DENW-1] ? -den : den;
  assign hi  = mn[NW-1:QW];
  // The quotient needs more than 32 bits exactly when the high part reaches the divisor.
  assign ovf = DENW'(hi) >= mdv;

  always_ff @(posedge clk) begin
    stage[0].rem        <= DENW'(hi);
    stage[0].lo         <= mn[QW-1:0];
    stage[0].md         <= mdv;
    stage[0].q          <= '0;
    stage[0].ctl.status <= in_status;
    stage[0].ctl.neg    <= num[NW-1] ^ den[DENW-1];
    stage[0].ctl.ovf    <= ovf;
    if (rst) begin
      stage[0].ctl.valid <= 1'b0;
    end else begin
      stage[0].ctl.valid <= in_valid;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    qli_div_step u_step (
      .clk  (clk),
      .rst  (rst),
      .din  (stage[i]),
      .dout (stage[i+1])
    );
  end

  assign dout = stage[QW];

endmodule

// ===== src/three_point_quadratic_interpolator.sv =====
// Three-point quadratic interpolator, top level.
// From start to done, a word passes through the five front stages, the 33-stage
// divider and the output register.
// Throughput: one word per cycle; busy is always low and done cannot be held off.
// Reset clears all valid bits; no result appears until a word is started.
// Depends on qli_pkg, qli_front and qli_divider.
module three_point_quadratic_interpolator import qli_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] query_x,
  input  logic signed [COORD_WIDTH-1:0] point0_x,
  input  logic signed [COORD_WIDTH-1:0] point0_y,
  input  logic signed [COORD_WIDTH-1:0] point1_x,
  input  logic signed [COORD_WIDTH-1:0] point1_y,
  input  logic signed [COORD_WIDTH-1:0] point2_x,
  input  logic signed [COORD_WIDTH-1:0] point2_y,
  output logic                          done,
  output logic signed [QW-1:0]          value,
  output logic [1:0]                    status,
  output logic                          saturated
);

  logic                   f_valid;
  status_t                f_status;
  logic signed [NW-1:0]   f_num;
  logic signed [DENW-1:0] f_den;
  div_t                   dq;

  logic [QW-1:0] value_next;
  logic          sat_next;

  assign busy = 1'b0;

  qli_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start),
    .qx         (query_x),
    .px0        (point0_x),
    .py0        (point0_y),
    .px1        (point1_x),
    .py1        (point1_y),
    .px2        (point2_x),
    .py2        (point2_y),
    .out_valid  (f_valid),
    .out_status (f_status),
    .num        (f_num),
    .den        (f_den)
  );

  qli_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_status (f_status),
    .num       (f_num),
    .den       (f_den),
    .dout      (dq)
  );

  // A negative quotient may reach magnitude 2^31; a positive one may not.
  always_comb begin
    value_next = '0;
    sat_next = 1'b0;
    if (dq.ctl.status == ST_UNDEF) begin
      value_next = '0;
    end else if (dq.ctl.neg) begin
      if (dq.ctl.ovf || (dq.q > {1'b1, {(QW-1){1'b0}}})) begin
        value_next = {1'b1, {(QW-1){1'b0}}};
        sat_next = 1'b1;
      end else begin
        value_next = -dq.q;
      end
    end else begin
      if (dq.ctl.ovf || dq.q[QW-1]) begin
        value_next = {1'b0, {(QW-1){1'b1}}};
        sat_next = 1'b1;
      end else begin
        value_next = dq.q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dq.ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    value     <= value_next;
    status    <= dq.ctl.status;
    saturated <= sat_next;
  end

endmodule
